// ===== rtl/anp_pkg.sv =====
// anp_pkg: shared types, character codes and digit helpers for the ASCII
// number parser.
// No dependencies.
package anp_pkg;

    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 64;
    localparam int PHASE_W = 3;
    localparam int DIGIT_W = 4;

    typedef logic [CHAR_W-1:0]  char_t;
    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [PHASE_W-1:0] phase_t;
    typedef logic [DIGIT_W-1:0] digit_t;

    localparam char_t CH_NUL   = 8'h00;
    localparam char_t CH_ZERO  = 8'h30;
    localparam char_t CH_NINE  = 8'h39;
    localparam char_t CH_LOW_A = 8'h61;
    localparam char_t CH_LOW_F = 8'h66;
    localparam char_t CH_UP_A  = 8'h41;
    localparam char_t CH_UP_F  = 8'h46;
    localparam char_t CH_LOW_X = 8'h78;
    localparam char_t CH_MINUS = 8'h2d;

    typedef struct packed {
        logic   ok;
        digit_t val;
    } digit_res_t;

    function automatic digit_res_t dec_digit(input char_t c);
        digit_res_t r;
        r.ok  = (c >= CH_ZERO) && (c <= CH_NINE);
        r.val = DIGIT_W'(c - CH_ZERO);
        return r;
    endfunction

    function automatic digit_res_t hex_digit(input char_t c);
        digit_res_t r;
        r.ok  = 1'b1;
        r.val = '0;
        if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
            r.val = DIGIT_W'(c - CH_ZERO);
        end else if ((c >= CH_LOW_A) && (c <= CH_LOW_F)) begin
            r.val = DIGIT_W'(c - CH_LOW_A + 8'd10);
        end else if ((c >= CH_UP_A) && (c <= CH_UP_F)) begin
            r.val = DIGIT_W'(c - CH_UP_A + 8'd10);
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== rtl/ascii_number_parser.sv =====
// ascii_number_parser: streaming ASCII-to-integer parser, decimal or 0x hex,
// signed or unsigned, one character per transaction.
// Depends on anp_pkg.
//
// channel  | dir | tdata                 | tuser
// s_       | in  | [7:0] character       | [0] signed_mode
// m_       | out | [63:0] value          | [0] bad_format
//
// One character is accepted per cycle while no NUL is held behind a stalled result;
// a result passes through the input register, then the result register.
// aresetn is synchronous, active low; it clears the parse state and both
// valid flags.
// A stalled result holds only the NUL behind it: other characters keep
// flowing through the input register while the result waits.
module ascii_number_parser (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  anp_pkg::char_t         s_tdata,   // [7:0] character
    input  logic                   s_tuser,   // [0] signed_mode
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output anp_pkg::value_t        m_tdata,   // [63:0] value
    output logic                   m_tuser    // [0] bad_format
);
    import anp_pkg::*;

    localparam phase_t PH_START = 3'd0;
    localparam phase_t PH_ZERO  = 3'd1;
    localparam phase_t PH_DEC   = 3'd2;
    localparam phase_t PH_HEX   = 3'd3;
    localparam phase_t PH_NEG   = 3'd4;
    localparam phase_t PH_BAD   = 3'd5;

    // input register
    logic   in_valid_reg;
    char_t  in_char_reg;
    logic   in_mode_reg;

    // parse state
    phase_t phase_reg, phase_next;
    value_t acc_reg, acc_next;
    logic   mode_latch_reg, mode_latch_next;

    // result register
    logic   out_valid_reg, out_valid_next;
    value_t out_value_reg, out_value_next;
    logic   out_bad_reg, out_bad_next;

    logic       is_nul;
    logic       advance;
    logic       mode_cur;
    digit_res_t dd, hd;
    value_t     dec_acc, hex_acc, low_ext;

    assign is_nul   = (in_char_reg == CH_NUL);
    assign advance  = in_valid_reg && (!is_nul || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_bad_reg;

    assign mode_cur = (phase_reg == PH_START) ? in_mode_reg : mode_latch_reg;
    assign dd       = dec_digit(in_char_reg);
    assign hd       = hex_digit(in_char_reg);
    assign dec_acc  = (acc_reg << 3) + (acc_reg << 1) + VALUE_W'(dd.val);
    assign hex_acc  = (acc_reg << 4) + VALUE_W'(hd.val);
    assign low_ext  = {{(VALUE_W-32){acc_reg[31]}}, acc_reg[31:0]};

    always_comb begin
        phase_next      = phase_reg;
        acc_next        = acc_reg;
        mode_latch_next = mode_cur;
        out_valid_next  = out_valid_reg && !m_tready;
        out_value_next  = out_value_reg;
        out_bad_next    = out_bad_reg;
        if (advance) begin
            if (is_nul) begin
                out_valid_next = 1'b1;
                out_bad_next   = (phase_reg >= PH_BAD);
                if (phase_reg >= PH_BAD) begin
                    out_value_next = '0;
                end else if (phase_reg == PH_NEG) begin
                    out_value_next = '0 - acc_reg;
                end else if (mode_cur) begin
                    out_value_next = low_ext;
                end else begin
                    out_value_next = acc_reg;
                end
                phase_next = PH_START;
                acc_next   = '0;
            end else begin
                unique case (phase_reg)
                    PH_START: begin
                        if (mode_cur && (in_char_reg == CH_MINUS)) begin
                            phase_next = PH_NEG;
                            acc_next   = '0;
                        end else if (in_char_reg == CH_ZERO) begin
                            phase_next = PH_ZERO;
                            acc_next   = '0;
                        end else if (dd.ok) begin
                            phase_next = PH_DEC;
                            acc_next   = VALUE_W'(dd.val);
                        end else begin
                            phase_next = PH_BAD;
                            acc_next   = '0;
                        end
                    end
                    PH_ZERO: begin
                        if (in_char_reg == CH_LOW_X) begin
                            phase_next = PH_HEX;
                            acc_next   = '0;
                        end else if (dd.ok) begin
                            phase_next = PH_DEC;
                            acc_next   = dec_acc;
                        end else begin
                            phase_next = PH_BAD;
                            acc_next   = '0;
                        end
                    end
                    PH_DEC, PH_NEG: begin
                        if (dd.ok) begin
                            acc_next = dec_acc;
                        end else begin
                            phase_next = PH_BAD;
                            acc_next   = '0;
                        end
                    end
                    PH_HEX: begin
                        if (hd.ok) begin
                            acc_next = hex_acc;
                        end else begin
                            phase_next = PH_BAD;
                            acc_next   = '0;
                        end
                    end
                    default: begin
                        phase_next = PH_BAD;
                        acc_next   = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            phase_reg      <= PH_START;
            acc_reg        <= '0;
            mode_latch_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                phase_reg      <= phase_next;
                acc_reg        <= acc_next;
                mode_latch_reg <= mode_latch_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata;
            in_mode_reg <= s_tuser;
        end
        out_value_reg <= out_value_next;
        out_bad_reg   <= out_bad_next;
    end

    a_phase_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= PH_BAD)
        else $error("parse phase out of range");

    a_start_acc_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_START) |-> (acc_reg == '0))
        else $error("accumulator not clear at start of string");

    a_bad_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_bad_reg) |-> (out_value_reg == '0))
        else $error("bad-format result carries a nonzero value");

    a_nul_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && is_nul) |=> (out_valid_reg && (phase_reg == PH_START)))
        else $error("terminator did not produce a result");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |-> !(advance && is_nul))
        else $error("pending result overwritten");

endmodule

// ===== tb/tb_ascii_number_parser.sv =====
`timescale 1ns / 100ps
// tb_ascii_number_parser: self-checking testbench for the streaming ASCII number parser.
// Drives random and directed character strings, predicts each result in the bench.
// Depends on anp_pkg and ascii_number_parser.
module tb_ascii_number_parser;
    import anp_pkg::*;

    localparam int  STIM_CHARS = 1600;
    localparam int  MAX_WAIT   = 13;
    localparam int  HOLD_LEN   = 300;
    localparam int  LIMIT      = 400000;
    localparam char_t CH_UP_X  = 8'h58;

    typedef enum logic [2:0] {
        STR_START, STR_LEAD_ZERO, STR_DEC, STR_HEX, STR_NEG, STR_BAD
    } str_state_e;

    typedef struct packed {
        char_t ch;
        logic  mode;
    } char_item_t;

    typedef struct packed {
        value_t value;
        logic   bad;
    } parse_result_t;

    logic   aclk     = 1'b0;
    logic   aresetn  = 1'b0;
    logic   s_tvalid = 1'b0;
    logic   s_tready;
    char_t  s_tdata  = '0;
    logic   s_tuser  = 1'b0;
    logic   m_tvalid;
    logic   m_tready = 1'b0;
    value_t m_tdata;
    logic   m_tuser;

    char_item_t    char_queue[$];
    parse_result_t expected_results[$];

    str_state_e str_state    = STR_START;
    value_t     acc          = '0;
    logic       signed_latch = 1'b0;

    int  n_items    = 0;
    int  n_in       = 0;
    int  errors     = 0;
    int  cycles     = 0;
    int  send_gap   = 0;
    int  stall_left = 0;
    bit  send_burst = 0;
    bit  take_burst = 0;
    bit  long_hold  = 0;
    bit  in_taken   = 0;
    bit  out_taken  = 0;

    ascii_number_parser uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // ---------------- prediction ----------------

    function automatic int digit_of(input char_t c, input bit hex);
        if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
        if (hex && c >= CH_LOW_A && c <= CH_LOW_F) return int'(c - CH_LOW_A) + 10;
        if (hex && c >= CH_UP_A && c <= CH_UP_F) return int'(c - CH_UP_A) + 10;
        return -1;
    endfunction

    function automatic void mark_bad();
        str_state = STR_BAD;
        acc       = '0;
    endfunction

    function automatic void add_dec(input char_t c);
        int d;
        d = digit_of(c, 1'b0);
        if (d < 0) mark_bad();
        else acc = acc * 64'd10 + value_t'(d);
    endfunction

    function automatic void parse_char(input char_t c, input logic mode,
                                       output bit done, output parse_result_t r);
        int d;
        done = 1'b0;
        r    = '0;
        if (str_state == STR_START) signed_latch = mode;
        if (c == CH_NUL) begin
            done = 1'b1;
            if (str_state == STR_BAD) r.bad = 1'b1;
            else if (str_state == STR_NEG) r.value = value_t'(0) - acc;
            else if (signed_latch) r.value = {{32{acc[31]}}, acc[31:0]};
            else r.value = acc;
            str_state = STR_START;
            acc       = '0;
            return;
        end
        case (str_state)
            STR_START: begin
                acc = '0;
                if (signed_latch && c == CH_MINUS) str_state = STR_NEG;
                else if (c == CH_ZERO) str_state = STR_LEAD_ZERO;
                else begin
                    str_state = STR_DEC;
                    add_dec(c);
                end
            end
            STR_LEAD_ZERO: begin
                if (c == CH_LOW_X) begin
                    str_state = STR_HEX;
                    acc       = '0;
                end else begin
                    str_state = STR_DEC;
                    add_dec(c);
                end
            end
            STR_DEC, STR_NEG: add_dec(c);
            STR_HEX: begin
                d = digit_of(c, 1'b1);
                if (d < 0) mark_bad();
                else acc = (acc << 4) + value_t'(d);
            end
            default: mark_bad();
        endcase
    endfunction

    // ---------------- stimulus ----------------

    function automatic char_t dec_char();
        return CH_ZERO + char_t'($urandom_range(0, 9));
    endfunction

    function automatic char_t hex_char();
        int d;
        d = $urandom_range(0, 15);
        if (d < 10) return CH_ZERO + char_t'(d);
        return ($urandom_range(0, 1) ? CH_LOW_A : CH_UP_A) + char_t'(d - 10);
    endfunction

    // first char carries the mode; the rest get random mode bits, which are ignored
    task automatic queue_string(input char_t txt[$], input logic mode);
        char_item_t it;
        foreach (txt[i]) begin
            it.ch   = txt[i];
            it.mode = (i == 0) ? mode : logic'($urandom_range(0, 1));
            char_queue.push_back(it);
        end
        it.ch   = CH_NUL;
        it.mode = (txt.size() == 0) ? mode : logic'($urandom_range(0, 1));
        char_queue.push_back(it);
    endtask

    task automatic queue_text(input string s, input logic mode);
        char_t txt[$];
        for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
        queue_string(txt, mode);
    endtask

    task automatic queue_random_string();
        char_t txt[$];
        int    kind;
        int    len;
        logic  mode;
        mode = logic'($urandom_range(0, 1));
        kind = $urandom_range(0, 9);
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 8);
        case (kind)
            0, 1, 2: begin
                if (mode && $urandom_range(0, 2) == 0) txt.push_back(CH_MINUS);
                repeat (len) txt.push_back(dec_char());
            end
            3, 4, 5: begin
                txt.push_back(CH_ZERO);
                txt.push_back(CH_LOW_X);
                repeat (len) txt.push_back(hex_char());
            end
            6: begin
                if ($urandom_range(0, 1)) begin
                    txt.push_back(CH_ZERO);
                    txt.push_back(CH_LOW_X);
                    repeat (len) txt.push_back(hex_char());
                end else begin
                    if (mode) txt.push_back(CH_MINUS);
                    repeat (len) txt.push_back(dec_char());
                end
                txt[$urandom_range(0, txt.size() - 1)] = char_t'($urandom_range(1, 255));
            end
            7: begin
                repeat (len) txt.push_back(char_t'($urandom_range(1, 255)));
            end
            8: begin
                case ($urandom_range(0, 4))
                    1: txt.push_back(CH_ZERO);
                    2: begin
                        txt.push_back(CH_ZERO);
                        txt.push_back(CH_LOW_X);
                    end
                    3: txt.push_back(CH_MINUS);
                    4: begin
                        txt.push_back(CH_ZERO);
                        txt.push_back(CH_UP_X);
                        txt.push_back(hex_char());
                    end
                    default: ;
                endcase
            end
            default: begin
                txt.push_back(CH_ZERO);
                repeat (len) txt.push_back(dec_char());
            end
        endcase
        queue_string(txt, mode);
    endtask

    function automatic int draw_wait(inout bit burst);
        if ($urandom_range(0, 39) == 0) burst = !burst;
        return burst ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // ---------------- driver ----------------

    always @(negedge aclk) begin : drv
        char_item_t nxt;
        if (aresetn && !(s_tvalid && !in_taken)) begin
            if (send_gap > 0) begin
                s_tvalid <= 1'b0;
                send_gap--;
            end else if (char_queue.size() > 0) begin
                nxt = char_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.ch;
                s_tuser  <= nxt.mode;
                send_gap = draw_wait(send_burst);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin : rcv
        int n;
        if (aresetn) begin
            if (long_hold) begin
                m_tready <= 1'b0;
            end else if (out_taken) begin
                n = draw_wait(take_burst);
                stall_left = n;
                m_tready <= (n == 0);
            end else if (stall_left > 0) begin
                m_tready <= (stall_left == 1);
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------- monitors ----------------

    always @(posedge aclk) begin : in_mon
        bit            done;
        parse_result_t r;
        in_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            parse_char(s_tdata, s_tuser, done, r);
            n_in++;
            if (done) expected_results.push_back(r);
        end
    end

    always @(posedge aclk) begin : out_mon
        parse_result_t want;
        out_taken <= aresetn && m_tvalid && m_tready;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected transaction: value %h bad_format %b", m_tdata, m_tuser);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (want.value !== m_tdata) begin
                    $error("value: expected %h, got %h", want.value, m_tdata);
                    errors++;
                end
                if (want.bad !== m_tuser) begin
                    $error("bad_format: expected %b, got %b", want.bad, m_tuser);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // long receiver stall while the sender keeps going
    initial begin
        wait (n_in >= 500);
        @(posedge aclk);
        long_hold <= 1'b1;
        repeat (HOLD_LEN) @(posedge aclk);
        long_hold <= 1'b0;
    end

    // ---------------- main sequence ----------------

    initial begin
        int directed;
        char_t txt[$];

        queue_text("", 1'b0);
        queue_text("0x", 1'b0);
        queue_text("-", 1'b1);
        queue_text("-", 1'b0);
        queue_text("-0x1", 1'b1);
        queue_text("0X1", 1'b0);
        txt.push_back(8'hff);
        queue_string(txt, 1'b1);
        queue_text("0xfA9", 1'b1);
        queue_text("-12", 1'b1);
        queue_text("09", 1'b0);
        directed = char_queue.size();
        while (char_queue.size() < directed + STIM_CHARS) queue_random_string();
        n_items = char_queue.size();

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (n_in < n_items) @(posedge aclk);
        while (expected_results.size() > 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (errors == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
